/* hdl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared request, result and cell types plus character and kind codes for
// the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // request payload
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_item;

    // result payload
    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } t_result;

    // one stored cell: attribute high byte, character low byte
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } t_cell;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_BLANK     = 8'h20;
    localparam logic [7:0] CH_PRINT_LO  = 8'h20;
    localparam logic [7:0] CH_PRINT_HI  = 8'h7F;

    localparam logic [7:0] ATTR_RESET = 8'h0F;

endpackage

/* hdl/tcw_cell_store.sv */
// ----------------------------------------------------------------------------
// tcw_cell_store
// Single-port-write, single-port-read cell memory with registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_store #(
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  tcw_pkg::t_cell           i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output tcw_pkg::t_cell           o_rd_data
);

    tcw_pkg::t_cell r_mem [DEPTH];
    tcw_pkg::t_cell r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: cell store with a ring of rows, cursor tracking,
// newline/backspace/wrap/scroll handling, clear and single-cell read.
// ----------------------------------------------------------------------------
//
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+----------------------
// request   | in        | start & !busy             | i_item   (t_item)
// result    | out       | o_res_strobe, one cycle   | o_result (t_result)
// config    | in        | i_cfg_valid & o_cfg_ready | i_cfg_data (attribute)
//
// Put (no scroll), read and unused kinds: a new request may follow every
//   cycle while busy is low; the result appears the cycle after.
// A put that scrolls blanks the old top row through the store write port,
//   one cell a cycle, with busy high. Clear sweeps every cell the same way.
// Reset: synchronous; a clearing pass over every cell follows,
//   busy high throughout. Config writes are taken at any time.
// The result side has no back-pressure; results are never held.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             start,
    output logic             busy,
    input  tcw_pkg::t_item   i_item,
    // result channel
    output logic             o_res_strobe,
    output tcw_pkg::t_result o_result,
    // attribute register write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);

    typedef enum logic {
        S_RUN,
        S_SWEEP
    } t_state;

    t_state r_state;

    // cursor and ring state
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_top;
    logic [7:0]        r_attr;

    // blanking sweep
    logic [ADDR_W-1:0] r_sweep_addr;
    logic [ADDR_W-1:0] r_sweep_last;
    logic [7:0]        r_sweep_attr;
    logic              r_pend;      // result owed when sweep finishes

    // result register
    logic              r_strobe;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [ADDR_W-1:0] r_out_pos;
    logic              r_out_rd;

    // put decode
    logic [ROW_W:0]    n_row_w;
    logic [COL_W:0]    n_col_w;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic              put_wr;
    logic [ROW_W-1:0]  put_wr_row;
    logic [COL_W-1:0]  put_wr_col;
    logic [7:0]        put_wr_ch;
    logic              scroll;
    logic [ROW_W-1:0]  n_top;

    // store ports
    logic              accept;
    logic              rd_ok;
    logic              st_wr_en;
    logic [ADDR_W-1:0] st_wr_addr;
    tcw_pkg::t_cell    st_wr_data;
    logic              st_rd_en;
    logic [ADDR_W-1:0] st_rd_addr;
    tcw_pkg::t_cell    st_rd_data;

    // visible row to physical row through the ring offset
    function automatic logic [ROW_W-1:0] phys_row(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] vis
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, vis};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] prow,
        input logic [COL_W-1:0] col
    );
        return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    assign busy        = (r_state == S_SWEEP);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // ---- put character: cursor step, cell write, wrap and scroll ----
    always_comb begin
        n_row_w    = {1'b0, r_row};
        n_col_w    = {1'b0, r_col};
        put_wr     = 1'b0;
        put_wr_row = r_row;
        put_wr_col = r_col;
        put_wr_ch  = tcw_pkg::CH_BLANK;
        scroll     = 1'b0;

        if (i_item.char_code == tcw_pkg::CH_NEWLINE) begin
            n_col_w = '0;
            n_row_w = {1'b0, r_row} + (ROW_W+1)'(1);
        end else if (i_item.char_code == tcw_pkg::CH_BACKSPACE) begin
            // back one cell, wrapping to the previous row; stays put at home
            if (r_col != '0) begin
                n_col_w = {1'b0, r_col} - (COL_W+1)'(1);
            end else if (r_row != '0) begin
                n_row_w = {1'b0, r_row} - (ROW_W+1)'(1);
                n_col_w = (COL_W+1)'(COLUMNS - 1);
            end
            put_wr     = 1'b1;
            put_wr_row = n_row_w[ROW_W-1:0];
            put_wr_col = n_col_w[COL_W-1:0];
        end else if (i_item.char_code inside
                     {[tcw_pkg::CH_PRINT_LO:tcw_pkg::CH_PRINT_HI]}) begin
            put_wr    = 1'b1;
            put_wr_ch = i_item.char_code;
            n_col_w   = {1'b0, r_col} + (COL_W+1)'(1);
        end

        if (n_col_w >= (COL_W+1)'(COLUMNS)) begin
            n_col_w = '0;
            n_row_w = n_row_w + (ROW_W+1)'(1);
        end
        if (n_row_w >= (ROW_W+1)'(ROWS)) begin
            scroll  = 1'b1;
            n_row_w = (ROW_W+1)'(ROWS - 1);
        end

        n_row = n_row_w[ROW_W-1:0];
        n_col = n_col_w[COL_W-1:0];
        n_top = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + ROW_W'(1);
    end

    // ---- store port muxing ----
    assign rd_ok = (32'(i_item.read_row) < ROWS) && (32'(i_item.read_col) < COLUMNS);

    always_comb begin
        if (r_state == S_SWEEP) begin
            st_wr_en        = 1'b1;
            st_wr_addr      = r_sweep_addr;
            st_wr_data.attr = r_sweep_attr;
            st_wr_data.ch   = tcw_pkg::CH_BLANK;
        end else begin
            st_wr_en        = accept && (i_item.kind == tcw_pkg::KIND_PUT) && put_wr;
            st_wr_addr      = cell_addr(phys_row(r_top, put_wr_row), put_wr_col);
            st_wr_data.attr = r_attr;
            st_wr_data.ch   = put_wr_ch;
        end
    end

    assign st_rd_en   = accept && (i_item.kind == tcw_pkg::KIND_READ) && rd_ok;
    assign st_rd_addr = cell_addr(phys_row(r_top, ROW_W'(i_item.read_row)),
                                  COL_W'(i_item.read_col));

    tcw_cell_store #(
        .DEPTH (CELLS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    // ---- state, cursor and result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;   // clearing pass over the whole store
            r_row        <= '0;
            r_col        <= '0;
            r_top        <= '0;
            r_attr       <= tcw_pkg::ATTR_RESET;
            r_sweep_addr <= '0;
            r_sweep_last <= ADDR_W'(CELLS - 1);
            r_sweep_attr <= tcw_pkg::ATTR_RESET;
            r_pend       <= 1'b0;
            r_strobe     <= 1'b0;
            r_out_rd     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_attr <= i_cfg_data;
            end

            case (r_state)
                S_RUN: begin
                    r_strobe <= 1'b0;
                    if (accept) begin
                        r_out_rd <= 1'b0;
                        case (i_item.kind)
                            tcw_pkg::KIND_PUT: begin
                                r_row     <= n_row;
                                r_col     <= n_col;
                                r_out_row <= n_row;
                                r_out_col <= n_col;
                                r_out_pos <= cell_addr(n_row, n_col);
                                if (scroll) begin
                                    // blank the old top row, which becomes the bottom
                                    r_top        <= n_top;
                                    r_sweep_addr <= cell_addr(r_top, '0);
                                    r_sweep_last <= cell_addr(r_top, '0)
                                                    + ADDR_W'(COLUMNS - 1);
                                    r_sweep_attr <= r_attr;
                                    r_pend       <= 1'b1;
                                    r_state      <= S_SWEEP;
                                end else begin
                                    r_strobe <= 1'b1;
                                end
                            end
                            tcw_pkg::KIND_CLEAR: begin
                                r_row        <= '0;
                                r_col        <= '0;
                                r_top        <= '0;
                                r_out_row    <= '0;
                                r_out_col    <= '0;
                                r_out_pos    <= '0;
                                r_sweep_addr <= '0;
                                r_sweep_last <= ADDR_W'(CELLS - 1);
                                r_sweep_attr <= r_attr;
                                r_pend       <= 1'b1;
                                r_state      <= S_SWEEP;
                            end
                            default: begin
                                // read, or unused kind: cursor only
                                r_out_row <= r_row;
                                r_out_col <= r_col;
                                r_out_pos <= cell_addr(r_row, r_col);
                                r_out_rd  <= (i_item.kind == tcw_pkg::KIND_READ) && rd_ok;
                                r_strobe  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    if (r_sweep_addr == r_sweep_last) begin
                        r_strobe <= r_pend;
                        r_pend   <= 1'b0;
                        r_state  <= S_RUN;
                    end else begin
                        r_strobe     <= 1'b0;
                        r_sweep_addr <= r_sweep_addr + ADDR_W'(1);
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    // ---- result ports ----
    assign o_res_strobe        = r_strobe;
    assign o_result.cursor_row = 5'(r_out_row);
    assign o_result.cursor_col = 7'(r_out_col);
    assign o_result.cursor_pos = 11'(r_out_pos);
    assign o_result.cell_char  = r_out_rd ? st_rd_data.ch   : 8'h00;
    assign o_result.cell_attr  = r_out_rd ? st_rd_data.attr : 8'h00;

    // ---- assertions ----
    a_cursor_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> (32'(r_out_row) < ROWS) && (32'(r_out_col) < COLUMNS))
        else $error("cursor reported outside the screen");

    a_top_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_top) < ROWS) && (32'(r_row) < ROWS))
        else $error("ring offset or cursor row out of range");

    a_read_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.kind == tcw_pkg::KIND_READ)) |=> (o_res_strobe && !busy))
        else $error("read request gave no result in the next cycle");

    a_sweep_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && (r_sweep_addr != r_sweep_last)) |=> !o_res_strobe)
        else $error("result strobed before blanking finished");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text console writer. A behavioural console
// (cell store, ring offset, cursor, attribute) predicts every result as
// requests are accepted. A checker compares each strobed result field by
// field. Stimulus runs from a short directed set, through wrap and scroll
// text, to a long weighted random stream under several attribute settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // unused kind code, not named in the package
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // clear and reset sweep each cover every cell; the limit allows several sweeps
    localparam int WATCHDOG_LIMIT   = 8 * CELLS;
    localparam int TAIL_CYCLES      = COLUMNS + 20;
    localparam int RANDOM_PHASES    = 6;
    localparam int RANDOM_PER_PHASE = 280;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    tcw_pkg::t_item   req_item;
    logic             res_strobe;
    tcw_pkg::t_result result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [7:0]       cfg_data;

    // expected results in request order
    tcw_pkg::t_result expected_results[$];
    int               mismatches;
    int               results_seen;
    int               idle_cycles;
    int               burst_left;

    // behavioural console state
    tcw_pkg::t_cell   cells [CELLS];
    int               cur_row;
    int               cur_col;
    int               top_ofs;
    logic [7:0]       attr_reg;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (req_item),
        .o_res_strobe (res_strobe),
        .o_result     (result),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Console predictor
    // ------------------------------------------------------------------------

    // cell at a visible row, mapped through the ring offset
    function automatic void write_cell(int vis_row, int col, logic [7:0] ch);
        int pr;
        pr = (top_ofs + vis_row) % ROWS;
        cells[pr * COLUMNS + col] = '{attr: attr_reg, ch: ch};
    endfunction

    function automatic void blank_phys_row(int pr);
        for (int c = 0; c < COLUMNS; c++) begin
            cells[pr * COLUMNS + c] = '{attr: attr_reg, ch: tcw_pkg::CH_BLANK};
        end
    endfunction

    function automatic void console_clear();
        for (int r = 0; r < ROWS; r++) begin
            blank_phys_row(r);
        end
        cur_row = 0;
        cur_col = 0;
        top_ofs = 0;
    endfunction

    function automatic void console_put(logic [7:0] ch);
        int old_top;
        if (ch == tcw_pkg::CH_NEWLINE) begin
            cur_col = 0;
            cur_row++;
        end else if (ch == tcw_pkg::CH_BACKSPACE) begin
            // steps back, wrapping to the previous row; stays put at home
            if (cur_col > 0) begin
                cur_col--;
            end else if (cur_row > 0) begin
                cur_row--;
                cur_col = COLUMNS - 1;
            end
            write_cell(cur_row, cur_col, tcw_pkg::CH_BLANK);
        end else if (ch >= tcw_pkg::CH_PRINT_LO && ch <= tcw_pkg::CH_PRINT_HI) begin
            write_cell(cur_row, cur_col, ch);
            cur_col++;
        end
        // other control bytes and the top half are ignored
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        // scroll: the old top row becomes the new, blank bottom row
        if (cur_row >= ROWS) begin
            old_top = top_ofs;
            top_ofs = (top_ofs + 1) % ROWS;
            blank_phys_row(old_top);
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic tcw_pkg::t_result console_step(tcw_pkg::t_item it);
        tcw_pkg::t_result r;
        int               pr;
        r = '0;
        case (it.kind)
            tcw_pkg::KIND_PUT: begin
                console_put(it.char_code);
            end
            tcw_pkg::KIND_READ: begin
                // out-of-screen reads give zero cell fields
                if (it.read_row < ROWS && it.read_col < COLUMNS) begin
                    pr = (top_ofs + it.read_row) % ROWS;
                    r.cell_char = cells[pr * COLUMNS + it.read_col].ch;
                    r.cell_attr = cells[pr * COLUMNS + it.read_col].attr;
                end
            end
            tcw_pkg::KIND_CLEAR: begin
                console_clear();
            end
            default: begin
                // spare kind: cursor only
            end
        endcase
        r.cursor_row = 5'(cur_row);
        r.cursor_col = 7'(cur_col);
        r.cursor_pos = 11'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    function automatic tcw_pkg::t_item make_item(logic [1:0] kind, logic [7:0] ch,
                                                 logic [4:0] row, logic [6:0] col);
        tcw_pkg::t_item it;
        it.kind      = kind;
        it.char_code = ch;
        it.read_row  = row;
        it.read_col  = col;
        return it;
    endfunction

    // random printable byte
    function automatic logic [7:0] random_print();
        return 8'($urandom_range(tcw_pkg::CH_PRINT_LO, tcw_pkg::CH_PRINT_HI));
    endfunction

    // Sends one request, predicts its result on acceptance, then paces the
    // sender: bursts of random length, random gaps, the odd long stretch.
    task automatic send_request(tcw_pkg::t_item it);
        int gap;
        start    <= 1'b1;
        req_item <= it;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(console_step(it));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                              : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(0, 30);
        end
    endtask

    // Holds off until every result is back and the block is idle.
    // It always waits on the clock before returning, so valids never toggle within one step.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0 || busy);
    endtask

    task automatic write_attribute(logic [7:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        attr_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // Weighted random request: mostly text, some control, reads near the
    // cursor, a little noise and the occasional clear.
    function automatic tcw_pkg::t_item random_console_item();
        int         pick;
        logic [4:0] row;
        logic [6:0] col;
        pick = $urandom_range(0, 999);
        row  = 5'($urandom_range(0, 31));
        col  = 7'($urandom_range(0, 127));
        if (pick < 600) begin
            return make_item(tcw_pkg::KIND_PUT, random_print(), row, col);
        end else if (pick < 680) begin
            return make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_NEWLINE, row, col);
        end else if (pick < 740) begin
            return make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BACKSPACE, row, col);
        end else if (pick < 770) begin
            return make_item(tcw_pkg::KIND_PUT, 8'($urandom_range(0, 255)), row, col);
        end else if (pick < 950) begin
            if ($urandom_range(0, 9) != 0) begin
                row = ($urandom_range(0, 1) == 0) ? 5'(cur_row)
                                                  : 5'($urandom_range(0, ROWS - 1));
                col = 7'($urandom_range(0, COLUMNS - 1));
            end
            return make_item(tcw_pkg::KIND_READ, 8'($urandom_range(0, 255)), row, col);
        end else if (pick < 995) begin
            return make_item(KIND_SPARE, 8'($urandom_range(0, 255)), row, col);
        end
        return make_item(tcw_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)), row, col);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        // backspace at home
        send_request(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_PUT, 8'h41, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_PRINT_HI, 5'd31, 7'd127));
        send_request(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_PRINT_LO, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_PUT, 8'h00, 5'd0, 7'd0));  // ignored
        send_request(make_item(tcw_pkg::KIND_PUT, 8'h1F, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_PUT, 8'h80, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_PUT, 8'hFF, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_READ, 8'hFF, 5'd0, 7'd1));
        send_request(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0));
        // backspace at column 0 wraps to the end of the row above
        send_request(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1)));
        // reads off the screen
        send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'(ROWS), 7'd0));
        send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'd0, 7'(COLUMNS)));
        send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'd31, 7'd127));
        send_request(make_item(KIND_SPARE, 8'hFF, 5'd31, 7'd127));
        send_request(make_item(tcw_pkg::KIND_CLEAR, 8'h00, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'd0, 7'd0));
    endtask

    // attribute extremes seen through clear, write and backspace blanking
    task automatic test_attribute_extremes();
        logic [7:0] values [3];
        values = '{8'h00, 8'hFF, tcw_pkg::ATTR_RESET};
        foreach (values[i]) begin
            write_attribute(values[i]);
            send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'd3, 7'd3));
            send_request(make_item(tcw_pkg::KIND_CLEAR, 8'h00, 5'd0, 7'd0));
            send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'd3, 7'd3));
            send_request(make_item(tcw_pkg::KIND_PUT, 8'h59, 5'd0, 7'd0));
            send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'd0, 7'd0));
            send_request(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0));
            send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'd0, 7'd0));
        end
    endtask

    // Well-formed text that wraps lines and scrolls, both by newline and by
    // running off the end of the bottom row, with reads of the moved rows.
    task automatic test_wrap_and_scroll();
        for (int i = 0; i < 2 * COLUMNS + 5; i++) begin
            send_request(make_item(tcw_pkg::KIND_PUT, random_print(), 5'd0, 7'd0));
        end
        for (int i = 0; i < ROWS + 3; i++) begin
            send_request(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0));
            send_request(make_item(tcw_pkg::KIND_READ, 8'h00,
                5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, 4))));
        end
        for (int i = 0; i < COLUMNS + 2; i++) begin
            send_request(make_item(tcw_pkg::KIND_PUT, random_print(), 5'd0, 7'd0));
        end
        send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'(ROWS - 2), 7'(COLUMNS - 1)));
        send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'(ROWS - 1), 7'd0));
        send_request(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0));
        send_request(make_item(tcw_pkg::KIND_READ, 8'h00, 5'(ROWS - 2), 7'(COLUMNS - 1)));
    endtask

    task automatic test_random_stream();
        logic [7:0] value;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                1:       value = 8'h00;
                2:       value = 8'hFF;
                4:       value = tcw_pkg::ATTR_RESET;
                default: value = 8'($urandom_range(0, 255));
            endcase
            write_attribute(value);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_request(random_console_item());
                // sender pause until the pipeline is empty
                if ($urandom_range(0, 199) == 0) begin
                    drain_results();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("mismatch: result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        tcw_pkg::t_result want;
        if (i_rst_n && res_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = expected_results.pop_front();
                if (result.cursor_row !== want.cursor_row)
                    report_mismatch($sformatf("cursor_row %0d, want %0d",
                                              result.cursor_row, want.cursor_row));
                if (result.cursor_col !== want.cursor_col)
                    report_mismatch($sformatf("cursor_col %0d, want %0d",
                                              result.cursor_col, want.cursor_col));
                if (result.cursor_pos !== want.cursor_pos)
                    report_mismatch($sformatf("cursor_pos %0d, want %0d",
                                              result.cursor_pos, want.cursor_pos));
                if (result.cell_char !== want.cell_char)
                    report_mismatch($sformatf("cell_char %h, want %h",
                                              result.cell_char, want.cell_char));
                if (result.cell_attr !== want.cell_attr)
                    report_mismatch($sformatf("cell_attr %h, want %h",
                                              result.cell_attr, want.cell_attr));
            end
            results_seen++;
        end
    end

    // watchdog: any accepted request, result or register write resets it
    always @(posedge i_clk) begin
        if ((start && !busy) || res_strobe || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        req_item    <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        idle_cycles <= 0;
        mismatches   = 0;
        results_seen = 0;
        burst_left   = 0;
        attr_reg     = tcw_pkg::ATTR_RESET;
        console_clear();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing sweep after reset shows as busy; requests wait on it

        test_directed();
        test_attribute_extremes();
        test_wrap_and_scroll();
        test_random_stream();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
